### sv/dcsg_pkg.sv
// shared types, codes and constants for the dose command safety gate
// no dependencies; used by every module of the block
package dcsg_pkg;

    localparam logic [31:0] DAY_SECONDS = 32'd86400;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_DOSE   = 2'd1;
    localparam logic [1:0] CMD_ARM    = 2'd2;
    localparam logic [1:0] CMD_DISARM = 2'd3;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_ARMED    = 2'd1;
    localparam logic [1:0] MODE_COOLDOWN = 2'd2;

    localparam logic [2:0] VERDICT_NONE       = 3'd0;
    localparam logic [2:0] VERDICT_EXECUTED   = 3'd1;
    localparam logic [2:0] VERDICT_DISARMED   = 3'd2;
    localparam logic [2:0] VERDICT_BAD_LENGTH = 3'd3;
    localparam logic [2:0] VERDICT_REPLAY     = 3'd4;
    localparam logic [2:0] VERDICT_COOLDOWN   = 3'd5;
    localparam logic [2:0] VERDICT_DAILY_CAP  = 3'd6;

    localparam logic [1:0] CFG_MAX_PULSE_MS      = 2'd0;
    localparam logic [1:0] CFG_COOLDOWN_SECONDS  = 2'd1;
    localparam logic [1:0] CFG_MAX_DOSES_PER_DAY = 2'd2;

    localparam logic [15:0] RST_MAX_PULSE_MS      = 16'd5000;
    localparam logic [15:0] RST_COOLDOWN_SECONDS  = 16'd60;
    localparam logic [7:0]  RST_MAX_DOSES_PER_DAY = 8'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] pulse_ms;
        logic [31:0] request_nonce;
        logic [31:0] now_seconds;
        logic        kill_switch;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] granted_ms;
        logic [1:0]  mode;
        logic        is_armed;
        logic [7:0]  dose_count;
        logic [31:0] spent_nonce;
        logic [31:0] last_dose_time;
    } t_out_word;

    typedef struct packed {
        logic [15:0] max_pulse_ms;
        logic [15:0] cooldown_seconds;
        logic [7:0]  max_doses_per_day;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        armed;
        logic [7:0]  day_count;
        logic [31:0] last_dose_stamp;
        logic [31:0] used_nonce;
        logic [31:0] day_anchor;
    } t_state;

endpackage

### sv/dose_command_safety_gate_unit.sv
// top level of the dose command safety gate: input register, gate state,
// result register; depends on dcsg_pkg, dcsg_cfg and dcsg_eval

// Each input word (tick, arm, disarm or dose request) yields exactly one result
// word. A word is captured in an input register, evaluated against the gate
// state combinationally, and its result lands in an output register while the
// state updates in the same edge, so the block sustains one word per clock
// while the downstream side does not stall. A word's result is held in the
// output register after the word has passed the input register. The input
// side stalls only while the input register is full and the output register
// holds a result the downstream side is stalling. Configuration writes take
// effect at the next edge and are meant to happen while no word is in flight.
module dose_command_safety_gate_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  dcsg_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dcsg_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    dcsg_pkg::t_cfg      cfg;
    dcsg_pkg::t_state    r_state;
    dcsg_pkg::t_state    n_state;
    dcsg_pkg::t_in_word  r_in_word;
    logic                r_in_valid;
    dcsg_pkg::t_out_word r_out_word;
    dcsg_pkg::t_out_word n_out_word;
    logic                r_out_valid;
    logic                advance;
    logic                accept;

    dcsg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dcsg_eval u_eval (
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_word  (n_out_word)
    );

    // the held word moves on when the output register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: dcsg_pkg::MODE_IDLE, armed: 1'b0, day_count: 8'd0,
                             last_dose_stamp: 32'd0, used_nonce: 32'd0,
                             day_anchor: 32'd0};
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### sv/dcsg_cfg.sv
// configuration register file: pulse limit, cooldown and daily cap
// depends on dcsg_pkg
module dcsg_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output dcsg_pkg::t_cfg      o_cfg
);

    dcsg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_pulse_ms      <= dcsg_pkg::RST_MAX_PULSE_MS;
            r_cfg.cooldown_seconds  <= dcsg_pkg::RST_COOLDOWN_SECONDS;
            r_cfg.max_doses_per_day <= dcsg_pkg::RST_MAX_DOSES_PER_DAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dcsg_pkg::CFG_MAX_PULSE_MS:      r_cfg.max_pulse_ms <= i_cfg_data;
                dcsg_pkg::CFG_COOLDOWN_SECONDS:  r_cfg.cooldown_seconds <= i_cfg_data;
                dcsg_pkg::CFG_MAX_DOSES_PER_DAY: r_cfg.max_doses_per_day <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/dcsg_eval.sv
// decision logic for one word: window roll, kill switch, cooldown exit,
// arm/disarm and the ordered dose checks; depends on dcsg_pkg
module dcsg_eval (
    input  dcsg_pkg::t_in_word  i_word,
    input  dcsg_pkg::t_cfg      i_cfg,
    input  dcsg_pkg::t_state    i_state,
    output dcsg_pkg::t_state    o_state,
    output dcsg_pkg::t_out_word o_word
);

    logic [31:0] anchor0;
    logic [31:0] since_anchor;
    logic [31:0] since_dose;
    logic        armed1;
    logic [1:0]  mode1;
    logic [2:0]  verdict;
    logic [15:0] granted;
    dcsg_pkg::t_state st;

    always_comb begin
        st      = i_state;
        verdict = dcsg_pkg::VERDICT_NONE;
        granted = 16'd0;

        // rolling day window, zero anchor means unset
        anchor0      = (i_state.day_anchor == 32'd0) ? i_word.now_seconds : i_state.day_anchor;
        since_anchor = i_word.now_seconds - anchor0;
        st.day_anchor = anchor0;
        if (since_anchor >= dcsg_pkg::DAY_SECONDS) begin
            st.day_anchor = i_word.now_seconds;
            st.day_count  = 8'd0;
        end

        armed1 = i_state.armed;
        mode1  = i_state.mode;
        if (i_word.kill_switch && armed1) begin
            armed1 = 1'b0;
            mode1  = dcsg_pkg::MODE_IDLE;
        end

        since_dose = i_word.now_seconds - i_state.last_dose_stamp;
        if (mode1 == dcsg_pkg::MODE_COOLDOWN &&
            since_dose >= {16'd0, i_cfg.cooldown_seconds}) begin
            mode1 = armed1 ? dcsg_pkg::MODE_ARMED : dcsg_pkg::MODE_IDLE;
        end

        st.armed = armed1;
        st.mode  = mode1;

        unique case (i_word.command)
            dcsg_pkg::CMD_ARM: begin
                if (!armed1) begin
                    st.armed = 1'b1;
                    st.mode  = dcsg_pkg::MODE_ARMED;
                end
            end
            dcsg_pkg::CMD_DISARM: begin
                if (armed1) begin
                    st.armed = 1'b0;
                    st.mode  = dcsg_pkg::MODE_IDLE;
                end
            end
            dcsg_pkg::CMD_DOSE: begin
                if (!armed1 || i_word.kill_switch) begin
                    verdict = dcsg_pkg::VERDICT_DISARMED;
                end else if (i_word.pulse_ms == 32'd0 ||
                             i_word.pulse_ms > {16'd0, i_cfg.max_pulse_ms}) begin
                    verdict = dcsg_pkg::VERDICT_BAD_LENGTH;
                end else if (i_word.request_nonce != 32'd0 &&
                             i_word.request_nonce == i_state.used_nonce) begin
                    verdict = dcsg_pkg::VERDICT_REPLAY;
                end else if (i_state.last_dose_stamp != 32'd0 &&
                             since_dose < {16'd0, i_cfg.cooldown_seconds}) begin
                    verdict = dcsg_pkg::VERDICT_COOLDOWN;
                end else if (st.day_count >= i_cfg.max_doses_per_day) begin
                    verdict = dcsg_pkg::VERDICT_DAILY_CAP;
                end else begin
                    verdict            = dcsg_pkg::VERDICT_EXECUTED;
                    granted            = i_word.pulse_ms[15:0];
                    st.last_dose_stamp = i_word.now_seconds;
                    st.used_nonce      = i_word.request_nonce;
                    st.day_count       = st.day_count + 8'd1;
                    st.mode            = dcsg_pkg::MODE_COOLDOWN;
                end
            end
            default: ;
        endcase
    end

    assign o_state               = st;
    assign o_word.verdict        = verdict;
    assign o_word.granted_ms     = granted;
    assign o_word.mode           = st.mode;
    assign o_word.is_armed       = st.armed;
    assign o_word.dose_count     = st.day_count;
    assign o_word.spent_nonce    = st.used_nonce;
    assign o_word.last_dose_time = st.last_dose_stamp;

endmodule
